### src/ctq_pkg.sv
// cancellable timer queue: shared types, constants and codes
// used by the interfaces, controller, datapath and top level; no dependencies
`default_nettype none

package ctq_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int DELAY_BITS    = 31;
  localparam int ID_BITS       = 32;
  localparam int COUNT_BITS    = 5;
  localparam int MAX_FIRE      = 16;
  localparam int FIRE_BITS     = $clog2(MAX_FIRE + 1);

  typedef enum logic [1:0] {
    OP_ADD        = 2'd0,
    OP_CANCEL     = 2'd1,
    OP_CANCEL_ALL = 2'd2,
    OP_TICK       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADD        = 2'd0,
    KIND_CANCEL     = 2'd1,
    KIND_CANCEL_ALL = 2'd2,
    KIND_FIRE       = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_REPLY,
    ST_FIRE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic scan_start;
    logic rd_en;
    logic push_reply;
    logic fire_take;
    logic flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_valid;
    op_t  op;
    logic hit;
    logic pend_valid;
    logic out_free;
  } ctl_stat_t;

endpackage

`default_nettype wire

### src/ctq_cmd_if.sv
// command channel: valid/ready handshake with the command payload
// depends on ctq_pkg for field widths
`default_nettype none

interface ctq_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     command;
  logic [ctq_pkg::DELAY_BITS-1:0] delay_ticks;
  logic [ctq_pkg::ID_BITS-1:0]    cancel_id;

  modport source (output valid, output command, output delay_ticks, output cancel_id,
                  input ready);
  modport sink (input valid, input command, input delay_ticks, input cancel_id,
                output ready);
endinterface

`default_nettype wire

### src/ctq_res_if.sv
// result channel: valid/ready handshake with the result payload
// depends on ctq_pkg for field widths
`default_nettype none

interface ctq_res_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [ctq_pkg::ID_BITS-1:0]    timer_id;
  logic                           ok;
  logic [ctq_pkg::COUNT_BITS-1:0] count;
  logic                           was_canceled;
  logic                           last;

  modport source (output valid, output kind, output timer_id, output ok, output count,
                  output was_canceled, output last, input ready);
  modport sink (input valid, input kind, input timer_id, input ok, input count,
                input was_canceled, input last, output ready);
endinterface

`default_nettype wire

### src/ctq_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ctq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/ctq_ctrl.sv
// controller: sequences scans over the entry store, fire passes and result pushes
// depends on ctq_pkg
`default_nettype none

module ctq_ctrl #(
  parameter int CAPACITY = ctq_pkg::CAPACITY_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ctq_pkg::ctl_stat_t          stat,
  output ctq_pkg::ctl_cmd_t                cmd,
  output logic [$clog2(CAPACITY)-1:0]      rd_addr
);
  import ctq_pkg::*;

  localparam int IDX_BITS = $clog2(CAPACITY);

  state_t               state, state_next;
  logic [IDX_BITS-1:0]  scan_idx, scan_idx_next;
  logic [FIRE_BITS-1:0] fire_cnt, fire_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_idx <= '0;
      fire_cnt <= '0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
      fire_cnt <= fire_cnt_next;
    end
  end

  always_comb begin
    cmd           = '0;
    state_next    = state;
    scan_idx_next = scan_idx;
    fire_cnt_next = fire_cnt;
    rd_addr       = scan_idx;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          scan_idx_next  = '0;
          fire_cnt_next  = '0;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (scan_idx == IDX_BITS'(CAPACITY - 1)) begin
          state_next = ST_DRAIN;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_next = (stat.op == OP_TICK) ? ST_FIRE : ST_REPLY;
      end
      ST_REPLY: begin
        if (stat.out_free) begin
          cmd.push_reply = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_FIRE: begin
        if (stat.hit) begin
          if (!stat.pend_valid || stat.out_free) begin
            cmd.fire_take = 1'b1;
            fire_cnt_next = fire_cnt + 1'b1;
            if (fire_cnt == FIRE_BITS'(MAX_FIRE - 1)) begin
              state_next = ST_FLUSH;
            end else begin
              cmd.scan_start = 1'b1;
              scan_idx_next  = '0;
              state_next     = ST_SCAN;
            end
          end
        end else begin
          state_next = stat.pend_valid ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/ctq_dpath.sv
// datapath: entry store, tick counter, id counter, scan compare and result register
// depends on ctq_pkg, ctq_ram, ctq_cmd_if and ctq_res_if
`default_nettype none

module ctq_dpath #(
  parameter int CAPACITY  = ctq_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = ctq_pkg::TIME_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  ctq_cmd_if.sink                          cmd_in,
  ctq_res_if.source                        res_out,
  input  wire ctq_pkg::ctl_cmd_t           cmd,
  input  wire logic [$clog2(CAPACITY)-1:0] rd_addr,
  output ctq_pkg::ctl_stat_t               stat
);
  import ctq_pkg::*;

  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int WORD_BITS = TIME_BITS + ID_BITS + 1;
  localparam logic [TIME_BITS-1:0]  HALF_M1   = {1'b0, {(TIME_BITS - 1){1'b1}}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // latched command
  op_t                   op;
  logic [DELAY_BITS-1:0] delay_q;
  logic [ID_BITS-1:0]    cid;

  logic [TIME_BITS-1:0]  tick_now;
  logic [ID_BITS-1:0]    next_ident;
  logic [CAPACITY-1:0]   valid;

  // scan stage
  logic                  proc_act;
  logic [IDX_BITS-1:0]   proc_idx;
  logic                  hit;
  logic [IDX_BITS-1:0]   best_idx;
  logic                  best_canc;
  logic [TIME_BITS-1:0]  best_over;
  logic [ID_BITS-1:0]    best_id;
  logic [COUNT_BITS-1:0] held;

  // fire waiting to learn whether it is the last
  logic                  pend_valid;
  logic [ID_BITS-1:0]    pend_id;
  logic                  pend_canc;

  // result register
  logic                  out_valid;
  kind_t                 out_kind;
  logic [ID_BITS-1:0]    out_id;
  logic                  out_ok;
  logic [COUNT_BITS-1:0] out_count;
  logic                  out_canc;
  logic                  out_last;

  logic                  we;
  logic [WORD_BITS-1:0]  wdata;
  logic [WORD_BITS-1:0]  rdata;
  logic                  rd_canc;
  logic [ID_BITS-1:0]    rd_id;
  logic [TIME_BITS-1:0]  rd_dl;
  logic [TIME_BITS-1:0]  delay_sat;
  logic [TIME_BITS-1:0]  overdue;
  logic [ID_BITS-1:0]    nid_inc;
  logic [ID_BITS-1:0]    new_id;
  logic                  ent_valid;
  logic                  due;
  logic                  ahead;
  logic                  wr_add;
  logic                  wr_can;
  logic                  wr_all;
  logic                  cand;
  logic                  out_free;
  logic                  push_fire;

  ctq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (proc_idx),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  generate
    if (TIME_BITS > DELAY_BITS) begin : g_wide_time
      assign delay_sat = TIME_BITS'(delay_q);
    end else begin : g_narrow_time
      assign delay_sat = (delay_q > DELAY_BITS'(HALF_M1)) ? HALF_M1
                                                           : delay_q[TIME_BITS-1:0];
    end
  endgenerate

  assign rd_canc   = rdata[WORD_BITS-1];
  assign rd_id     = rdata[TIME_BITS +: ID_BITS];
  assign rd_dl     = rdata[TIME_BITS-1:0];
  assign ent_valid = valid[proc_idx];
  assign overdue   = tick_now - rd_dl;
  assign due       = rd_canc || !overdue[TIME_BITS-1];
  assign nid_inc   = next_ident + 1'b1;
  assign new_id    = (nid_inc == '0) ? ID_BITS'(1) : nid_inc;

  always_comb begin
    if (rd_canc != best_canc) begin
      ahead = rd_canc;
    end else if (!rd_canc && overdue != best_over) begin
      ahead = overdue > best_over;
    end else begin
      ahead = rd_id < best_id;
    end
  end

  assign wr_add = proc_act && op == OP_ADD && !ent_valid && !hit;
  assign wr_can = proc_act && op == OP_CANCEL && ent_valid && !rd_canc && rd_id == cid && !hit;
  assign wr_all = proc_act && op == OP_CANCEL_ALL && ent_valid;
  assign cand   = proc_act && op == OP_TICK && ent_valid && due && (!hit || ahead);
  assign we     = wr_add || wr_can || wr_all;
  assign wdata  = wr_add ? {1'b0, new_id, tick_now + delay_sat} : {1'b1, rd_id, tick_now};

  assign out_free  = !out_valid || res_out.ready;
  assign push_fire = cmd.fire_take && pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      op         <= OP_ADD;
      tick_now   <= '0;
      next_ident <= '0;
      valid      <= '0;
      proc_act   <= 1'b0;
      hit        <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      proc_act <= cmd.rd_en;
      if (cmd.load) begin
        op <= op_t'(cmd_in.command);
        if (op_t'(cmd_in.command) == OP_TICK) begin
          tick_now <= tick_now + 1'b1;
        end
      end
      if (wr_add) begin
        next_ident      <= new_id;
        valid[proc_idx] <= 1'b1;
      end
      if (cmd.fire_take) begin
        valid[best_idx] <= 1'b0;
      end
      if (cmd.scan_start) begin
        hit <= 1'b0;
      end else if (wr_add || wr_can || cand) begin
        hit <= 1'b1;
      end
      if (cmd.fire_take) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
      if (cmd.push_reply || cmd.flush || push_fire) begin
        out_valid <= 1'b1;
      end else if (res_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= rd_addr;
    if (cmd.load) begin
      delay_q <= cmd_in.delay_ticks;
      cid     <= cmd_in.cancel_id;
    end
    if (cmd.scan_start) begin
      held <= '0;
    end else if (wr_all && held != COUNT_MAX) begin
      held <= held + 1'b1;
    end
    if (cand) begin
      best_idx  <= proc_idx;
      best_canc <= rd_canc;
      best_over <= overdue;
      best_id   <= rd_id;
    end
    if (cmd.fire_take) begin
      pend_id   <= best_id;
      pend_canc <= best_canc;
    end
    if (cmd.push_reply) begin
      out_canc <= 1'b0;
      out_last <= 1'b1;
      unique case (op)
        OP_ADD: begin
          out_kind  <= KIND_ADD;
          out_id    <= hit ? next_ident : '0;
          out_ok    <= hit;
          out_count <= '0;
        end
        OP_CANCEL: begin
          out_kind  <= KIND_CANCEL;
          out_id    <= cid;
          out_ok    <= hit;
          out_count <= '0;
        end
        OP_CANCEL_ALL: begin
          out_kind  <= KIND_CANCEL_ALL;
          out_id    <= '0;
          out_ok    <= 1'b0;
          out_count <= held;
        end
        OP_TICK: begin
          out_kind  <= KIND_FIRE;
          out_id    <= '0;
          out_ok    <= 1'b0;
          out_count <= '0;
        end
      endcase
    end else if (cmd.flush || push_fire) begin
      out_kind  <= KIND_FIRE;
      out_id    <= pend_id;
      out_ok    <= 1'b0;
      out_count <= '0;
      out_canc  <= pend_canc;
      out_last  <= cmd.flush;
    end
  end

  assign cmd_in.ready         = cmd.in_ready;
  assign res_out.valid        = out_valid;
  assign res_out.kind         = out_kind;
  assign res_out.timer_id     = out_id;
  assign res_out.ok           = out_ok;
  assign res_out.count        = out_count;
  assign res_out.was_canceled = out_canc;
  assign res_out.last         = out_last;

  assign stat.in_valid   = cmd_in.valid;
  assign stat.op         = op;
  assign stat.hit        = hit;
  assign stat.pend_valid = pend_valid;
  assign stat.out_free   = out_free;

endmodule

`default_nettype wire

### src/cancellable_timer_queue_unit.sv
// Timer queue with cancel: holds up to CAPACITY timers against an internal tick count.
// An add, cancel or cancel-all beat gets its reply after one pass over the entry ram at one
// entry per cycle plus the registered read, and once the result register is free.
// A tick beat takes one such pass per fired timer plus a final pass that finds nothing due,
// left out once the limit of 16 fires per tick is reached; a tick with nothing due
// gives no result. One command is worked at a time; the next is taken once the previous
// one's results are all in or through the result register. Deadlines wrap modulo
// 2^TIME_BITS and a timer is due once it is less than half the time range overdue.
// top level; depends on ctq_pkg, ctq_cmd_if, ctq_res_if, ctq_ctrl, ctq_dpath, ctq_ram
`default_nettype none

module cancellable_timer_queue_unit #(
  parameter int CAPACITY  = ctq_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = ctq_pkg::TIME_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  ctq_cmd_if.sink   cmd_in,
  ctq_res_if.source res_out
);
  import ctq_pkg::*;

  ctl_cmd_t                    ctl_cmd;
  ctl_stat_t                   ctl_stat;
  logic [$clog2(CAPACITY)-1:0] rd_addr;

  ctq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .stat    (ctl_stat),
    .cmd     (ctl_cmd),
    .rd_addr (rd_addr)
  );

  ctq_dpath #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd_in  (cmd_in),
    .res_out (res_out),
    .cmd     (ctl_cmd),
    .rd_addr (rd_addr),
    .stat    (ctl_stat)
  );

`ifndef SYNTHESIS
  a_push_into_free: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.push_reply |-> ctl_stat.out_free)
    else $error("reply pushed into an occupied result register");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (cmd_in.valid && cmd_in.ready) |=> !cmd_in.ready)
    else $error("command taken while another is in progress");

  a_fire_has_winner: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.fire_take |-> ctl_stat.hit)
    else $error("fire taken without a due entry");

  a_flush_has_pending: assert property (@(posedge clk) disable iff (rst)
    ctl_cmd.flush |-> ctl_stat.pend_valid)
    else $error("final fire pushed with nothing pending");
`endif

endmodule

`default_nettype wire
